@@ rtl/u8lcd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8lcd_pkg
// Shared types, constants and the two-byte letter table for the column writer.
// ----------------------------------------------------------------------------
package u8lcd_pkg;

  localparam int unsigned MAX_COLUMNS = 40;
  localparam int unsigned COL_W       = 6;

  localparam logic [COL_W-1:0] MAX_COL_C = COL_W'(MAX_COLUMNS);

  localparam logic [COL_W-1:0] RST_COLUMN_LIMIT  = 6'd16;
  localparam logic [7:0]       RST_PAD_CHARACTER = 8'h20;
  localparam logic             RST_PAD_ENABLE    = 1'b1;

  localparam logic [7:0] QMARK_C = 8'h3F;

  typedef enum logic [1:0] {
    CFG_COLUMN_LIMIT  = 2'd0,
    CFG_PAD_CHARACTER = 2'd1,
    CFG_PAD_ENABLE    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [COL_W-1:0] column_limit;
    logic [7:0]       pad_character;
    logic             pad_enable;
  } cfg_t;

  // one queued word: a character, or a terminator with its end details
  typedef struct packed {
    logic             is_term;
    logic             qmark;
    logic [7:0]       ch;
    logic [COL_W-1:0] left;
  } cmd_t;

  function automatic logic [7:0] map_pair(input logic [7:0] lead, input logic [7:0] trail);
    logic [7:0] res;
    case ({lead, trail})
      16'hC485: res = 8'h61;
      16'hC487: res = 8'h63;
      16'hC499: res = 8'h65;
      16'hC582: res = 8'h6C;
      16'hC584: res = 8'h6E;
      16'hC3B3: res = 8'h6F;
      16'hC59B: res = 8'h73;
      16'hC5BA: res = 8'h7A;
      16'hC5BC: res = 8'h7A;
      16'hC484: res = 8'h41;
      16'hC486: res = 8'h43;
      16'hC498: res = 8'h45;
      16'hC581: res = 8'h4C;
      16'hC583: res = 8'h4E;
      16'hC393: res = 8'h4F;
      16'hC59A: res = 8'h53;
      16'hC5B9: res = 8'h5A;
      16'hC5BB: res = 8'h5A;
      default:  res = QMARK_C;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/u8lcd_if.sv @@
// ----------------------------------------------------------------------------
// u8lcd_if
// Valid/ready channel interfaces: text input, display output, register write.
// ----------------------------------------------------------------------------
interface u8lcd_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

interface u8lcd_disp_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     display_char;
  logic                           char_valid;
  logic [u8lcd_pkg::COL_W-1:0]    columns_left;
  logic                           end_of_string;

  modport source (output valid, output display_char, output char_valid,
                  output columns_left, output end_of_string, input ready);
  modport sink   (input valid, input display_char, input char_valid,
                  input columns_left, input end_of_string, output ready);
endinterface

interface u8lcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/utf8_polish_to_lcd_column_writer_core.sv @@
// A word is stored in the command queue and then in the back end's output register before it shows on out_ch.
// Throughput: one text byte per cycle while the two-word command queue has room.
// A terminator expands to up to MAX_COLUMNS words, one per cycle while out_ch is ready;
// bytes keep being taken meanwhile until the queue fills.
// Reset: synchronous, active low; registers return to limit 16, pad 0x20, pad on.
// ----------------------------------------------------------------------------
// utf8_polish_to_lcd_column_writer_core
// Top level: configuration registers, front end, command queue and back end.
// ----------------------------------------------------------------------------
module utf8_polish_to_lcd_column_writer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  u8lcd_text_if.sink           in_ch,
  u8lcd_disp_if.source         out_ch,
  u8lcd_cfg_if.sink            cfg_ch
);

  u8lcd_pkg::cfg_t cfg_r;
  u8lcd_pkg::cmd_t push_cmd;
  u8lcd_pkg::cmd_t head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            head_valid;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.column_limit  <= u8lcd_pkg::RST_COLUMN_LIMIT;
      cfg_r.pad_character <= u8lcd_pkg::RST_PAD_CHARACTER;
      cfg_r.pad_enable    <= u8lcd_pkg::RST_PAD_ENABLE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        u8lcd_pkg::CFG_COLUMN_LIMIT:  cfg_r.column_limit  <= cfg_ch.data[u8lcd_pkg::COL_W-1:0];
        u8lcd_pkg::CFG_PAD_CHARACTER: cfg_r.pad_character <= cfg_ch.data;
        u8lcd_pkg::CFG_PAD_ENABLE:    cfg_r.pad_enable    <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  u8lcd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .text_valid (in_ch.valid),
    .text_byte  (in_ch.text_byte),
    .text_ready (in_ch.ready),
    .q_full     (q_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  u8lcd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  u8lcd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_char       (out_ch.display_char),
    .out_char_valid (out_ch.char_valid),
    .out_left       (out_ch.columns_left),
    .out_end        (out_ch.end_of_string)
  );

`ifndef SYNTHESIS
  a_left_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.end_of_string |-> out_ch.columns_left == '0)
    else $error("columns_left set on a word that does not end the string");

  a_report_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.char_valid |-> out_ch.end_of_string && out_ch.display_char == 8'h00)
    else $error("pure end report malformed");

  a_left_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.columns_left <= u8lcd_pkg::MAX_COL_C)
    else $error("columns_left beyond column maximum");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("command pushed into full queue");
`endif

endmodule

@@ rtl/u8lcd_front.sv @@
// ----------------------------------------------------------------------------
// u8lcd_front
// Accepts text bytes, pairs lead bytes, counts columns and queues commands.
// ----------------------------------------------------------------------------
module u8lcd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u8lcd_pkg::cfg_t               cfg,
  input  logic                          text_valid,
  input  logic [7:0]                    text_byte,
  output logic                          text_ready,
  input  logic                          q_full,
  output logic                          push,
  output u8lcd_pkg::cmd_t               push_cmd
);

  logic                          lead_r, lead_nxt;
  logic [7:0]                    held_r, held_nxt;
  logic [u8lcd_pkg::COL_W-1:0]   used_r, used_nxt;
  logic [u8lcd_pkg::COL_W-1:0]   lim;
  logic [u8lcd_pkg::COL_W-1:0]   used_end;
  logic                          full;
  logic                          acc;

  assign text_ready = !q_full;
  assign acc        = text_valid && text_ready;
  assign lim        = (cfg.column_limit > u8lcd_pkg::MAX_COL_C) ?
                      u8lcd_pkg::MAX_COL_C : cfg.column_limit;
  assign full       = used_r >= lim;

  always_comb begin
    lead_nxt          = lead_r;
    held_nxt          = held_r;
    used_nxt          = used_r;
    push              = 1'b0;
    push_cmd.is_term  = 1'b0;
    push_cmd.qmark    = 1'b0;
    push_cmd.ch       = text_byte;
    push_cmd.left     = '0;
    used_end          = used_r;
    if (acc) begin
      if (text_byte != 8'h00) begin
        if (full) begin
          lead_nxt = 1'b0;
          held_nxt = '0;
        end else if (lead_r) begin
          push        = 1'b1;
          push_cmd.ch = u8lcd_pkg::map_pair(held_r, text_byte);
          lead_nxt    = 1'b0;
          held_nxt    = '0;
          used_nxt    = used_r + 1'b1;
        end else if (text_byte[7]) begin
          lead_nxt = 1'b1;
          held_nxt = text_byte;
        end else begin
          push     = 1'b1;
          used_nxt = used_r + 1'b1;
        end
      end else begin
        push             = 1'b1;
        push_cmd.is_term = 1'b1;
        push_cmd.qmark   = lead_r && !full;
        push_cmd.ch      = '0;
        used_end         = used_r + {{(u8lcd_pkg::COL_W-1){1'b0}}, push_cmd.qmark};
        push_cmd.left    = (used_end < lim) ? (lim - used_end) : '0;
        lead_nxt         = 1'b0;
        held_nxt         = '0;
        used_nxt         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 1'b0;
      held_r <= '0;
      used_r <= '0;
    end else begin
      lead_r <= lead_nxt;
      held_r <= held_nxt;
      used_r <= used_nxt;
    end
  end

endmodule

@@ rtl/u8lcd_fifo.sv @@
// ----------------------------------------------------------------------------
// u8lcd_fifo
// Two-word command queue between the front and back ends.
// ----------------------------------------------------------------------------
module u8lcd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8lcd_pkg::cmd_t  push_cmd,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output u8lcd_pkg::cmd_t  head
);

  u8lcd_pkg::cmd_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            do_pop;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

@@ rtl/u8lcd_back.sv @@
// ----------------------------------------------------------------------------
// u8lcd_back
// Expands queued commands into display words: characters, '?', pads, end.
// ----------------------------------------------------------------------------
module u8lcd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u8lcd_pkg::cfg_t               cfg,
  input  logic                          head_valid,
  input  u8lcd_pkg::cmd_t               head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_char,
  output logic                          out_char_valid,
  output logic [u8lcd_pkg::COL_W-1:0]   out_left,
  output logic                          out_end
);

  logic                          valid_r;
  logic                          qdone_r, qdone_nxt;
  logic [u8lcd_pkg::COL_W-1:0]   cnt_r, cnt_nxt;
  logic [u8lcd_pkg::COL_W-1:0]   cnt_inc;
  logic [7:0]                    char_r, char_nxt;
  logic                          cv_r, cv_nxt;
  logic [u8lcd_pkg::COL_W-1:0]   left_r, left_nxt;
  logic                          end_r, end_nxt;
  logic                          load;
  logic                          emit;
  logic                          last;

  assign load    = !valid_r || out_ready;
  assign emit    = head_valid && load;
  assign pop     = emit && last;
  assign cnt_inc = cnt_r + 1'b1;

  always_comb begin
    char_nxt  = head.ch;
    cv_nxt    = 1'b1;
    left_nxt  = '0;
    end_nxt   = 1'b0;
    last      = 1'b1;
    qdone_nxt = qdone_r;
    cnt_nxt   = cnt_r;
    if (head.is_term) begin
      if (head.qmark && !qdone_r) begin
        char_nxt  = u8lcd_pkg::QMARK_C;
        last      = 1'b0;
        qdone_nxt = 1'b1;
      end else if (cfg.pad_enable && head.left != '0) begin
        char_nxt = cfg.pad_character;
        last     = cnt_inc == head.left;
        end_nxt  = last;
        left_nxt = last ? head.left : '0;
        cnt_nxt  = cnt_inc;
      end else begin
        char_nxt = '0;
        cv_nxt   = 1'b0;
        left_nxt = head.left;
        end_nxt  = 1'b1;
      end
    end
    if (last) begin
      qdone_nxt = 1'b0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      qdone_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= head_valid;
      end
      if (emit) begin
        qdone_r <= qdone_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= char_nxt;
      cv_r   <= cv_nxt;
      left_r <= left_nxt;
      end_r  <= end_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_char       = char_r;
  assign out_char_valid = cv_r;
  assign out_left       = left_r;
  assign out_end        = end_r;

endmodule

@@ bench/utf8_polish_to_lcd_column_writer_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_polish_to_lcd_column_writer_core_tb
// Feeds zero-terminated UTF-8 text through the column writer and predicts
// every display word: pass-through bytes, Polish two-byte letters, bad pairs,
// column limit, padding and end reports, checked in order as words arrive.
// ----------------------------------------------------------------------------
module utf8_polish_to_lcd_column_writer_core_tb;

  localparam logic [7:0] TERMINATOR   = 8'h00;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         HOLD_CYCLES  = 90;
  localparam int         PHASE_ITEMS  = 55;

  typedef struct packed {
    logic [7:0]                  ch;
    logic                        shown;
    logic [u8lcd_pkg::COL_W-1:0] left;
    logic                        last;
  } disp_word_t;

  logic clk = 1'b0;
  logic rst_n;

  u8lcd_text_if in_if();
  u8lcd_disp_if out_if();
  u8lcd_cfg_if  cfg_if();

  utf8_polish_to_lcd_column_writer_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted register and string state
  logic [u8lcd_pkg::COL_W-1:0] lim_reg  = u8lcd_pkg::RST_COLUMN_LIMIT;
  logic [7:0]       pad_char = u8lcd_pkg::RST_PAD_CHARACTER;
  logic             pad_on   = u8lcd_pkg::RST_PAD_ENABLE;
  logic             lead_held = 1'b0;
  logic [7:0]       lead_byte = 8'h00;
  int unsigned      cols_used = 0;

  disp_word_t  expected_words[$];
  int unsigned errors     = 0;
  int unsigned text_count = 0;
  logic        tx_gaps    = 1'b0;
  logic        rx_gaps    = 1'b0;
  int unsigned rx_wait    = 0;
  int unsigned hold_req   = 0;
  int unsigned hold_cnt   = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [7:0] polish_letter(input logic [7:0] lead, input logic [7:0] trail);
    logic [7:0] res;
    res = u8lcd_pkg::QMARK_C;
    case (lead)
      8'hC3: case (trail)
        8'h93: res = "O";
        8'hB3: res = "o";
        default: ;
      endcase
      8'hC4: case (trail)
        8'h84: res = "A";
        8'h85: res = "a";
        8'h86: res = "C";
        8'h87: res = "c";
        8'h98: res = "E";
        8'h99: res = "e";
        default: ;
      endcase
      8'hC5: case (trail)
        8'h81: res = "L";
        8'h82: res = "l";
        8'h83: res = "N";
        8'h84: res = "n";
        8'h9A: res = "S";
        8'h9B: res = "s";
        8'hB9, 8'hBB: res = "Z";
        8'hBA, 8'hBC: res = "z";
        default: ;
      endcase
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [15:0] polish_code(input int unsigned idx);
    case (idx)
      0:  return 16'hC485;
      1:  return 16'hC487;
      2:  return 16'hC499;
      3:  return 16'hC582;
      4:  return 16'hC584;
      5:  return 16'hC3B3;
      6:  return 16'hC59B;
      7:  return 16'hC5BA;
      8:  return 16'hC5BC;
      9:  return 16'hC484;
      10: return 16'hC486;
      11: return 16'hC498;
      12: return 16'hC581;
      13: return 16'hC583;
      14: return 16'hC393;
      15: return 16'hC59A;
      16: return 16'hC5B9;
      default: return 16'hC5BB;
    endcase
  endfunction

  function automatic void push_word(input logic [7:0] ch, input logic shown,
                                    input int unsigned left, input logic last);
    disp_word_t w;
    w.ch    = ch;
    w.shown = shown;
    w.left  = left[u8lcd_pkg::COL_W-1:0];
    w.last  = last;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_text_byte(input logic [7:0] b);
    int unsigned lim;
    int unsigned left;
    lim = (lim_reg > u8lcd_pkg::MAX_COLUMNS) ? u8lcd_pkg::MAX_COLUMNS : int'(lim_reg);
    if (b != TERMINATOR) begin
      if (cols_used >= lim) begin
        lead_held = 1'b0;
        lead_byte = 8'h00;
        return;
      end
      if (lead_held) begin
        push_word(polish_letter(lead_byte, b), 1'b1, 0, 1'b0);
        lead_held = 1'b0;
        lead_byte = 8'h00;
        cols_used++;
      end else if (b[7]) begin
        lead_held = 1'b1;
        lead_byte = b;
      end else begin
        push_word(b, 1'b1, 0, 1'b0);
        cols_used++;
      end
      return;
    end
    if (lead_held && cols_used < lim) begin
      push_word(u8lcd_pkg::QMARK_C, 1'b1, 0, 1'b0);
      cols_used++;
    end
    left = (cols_used < lim) ? lim - cols_used : 0;
    if (pad_on && left > 0) begin
      for (int unsigned i = 0; i < left; i++)
        push_word(pad_char, 1'b1, (i + 1 == left) ? left : 0, i + 1 == left);
    end else begin
      push_word(8'h00, 1'b0, left, 1'b1);
    end
    lead_held = 1'b0;
    lead_byte = 8'h00;
    cols_used = 0;
  endfunction

  // result side: check each word, then draw the next receive gap
  always @(posedge clk) begin
    disp_word_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_if.display_char, 0);
      end else begin
        w = expected_words.pop_front();
        if (out_if.display_char !== w.ch)
          report_mismatch("display_char", out_if.display_char, w.ch);
        if (out_if.char_valid !== w.shown)
          report_mismatch("char_valid", out_if.char_valid, w.shown);
        if (out_if.columns_left !== w.left)
          report_mismatch("columns_left", out_if.columns_left, w.left);
        if (out_if.end_of_string !== w.last)
          report_mismatch("end_of_string", out_if.end_of_string, w.last);
      end
      rx_wait = rx_gaps ? $urandom_range(0, 17) : 0;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      out_if.ready <= 1'b0;
    end else if (rx_wait != 0) begin
      out_if.ready <= 1'b0;
      rx_wait--;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_text(input logic [7:0] b);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 17) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.text_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_text_byte(b);
    text_count++;
  endtask

  task automatic send_ascii(input string s);
    for (int i = 0; i < s.len(); i++) send_text(s[i]);
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      u8lcd_pkg::CFG_COLUMN_LIMIT:  lim_reg  = data[u8lcd_pkg::COL_W-1:0];
      u8lcd_pkg::CFG_PAD_CHARACTER: pad_char = data;
      u8lcd_pkg::CFG_PAD_ENABLE:    pad_on   = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] lim, input logic [7:0] pad, input logic [7:0] en);
    write_reg(u8lcd_pkg::CFG_COLUMN_LIMIT, lim);
    write_reg(u8lcd_pkg::CFG_PAD_CHARACTER, pad);
    write_reg(u8lcd_pkg::CFG_PAD_ENABLE, en);
  endtask

  task automatic send_random_string();
    int unsigned len;
    int unsigned kind;
    logic [15:0] code;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 10);
    for (int unsigned k = 0; k < len; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        send_text(8'($urandom_range(1, 127)));
      end else if (kind < 80) begin
        code = polish_code($urandom_range(0, 17));
        send_text(code[15:8]);
        send_text(code[7:0]);
      end else if (kind < 92) begin
        send_text(8'($urandom_range(128, 255)));
        send_text(8'($urandom_range(1, 255)));
      end else begin
        send_text(8'($urandom_range(128, 255)));
      end
    end
    if ($urandom_range(0, 7) == 0) send_text(8'($urandom_range(128, 255)));
    send_text(TERMINATOR);
  endtask

  // byte extremes at reset settings
  task automatic test_plain_bytes();
    send_text(8'h01);
    send_text(8'h7F);
    send_text("A");
    send_text(TERMINATOR);
    wait_drain();
  endtask

  task automatic test_lead_bytes();
    send_text(8'hC4); send_text(8'h85);
    send_text(8'hC5); send_text(8'hBC);
    send_text(8'hC3); send_text(8'h93);
    send_text(8'hC4); send_text(8'hC4);
    send_text(8'hFF); send_text(8'h80);
    send_text(8'h80);
    send_text(TERMINATOR);
    send_text(TERMINATOR);
    wait_drain();
  endtask

  task automatic test_column_limit();
    set_config(8'd1, 8'hFF, 8'd0);
    send_ascii("ab");
    send_text(TERMINATOR);
    send_text(8'hC4);
    send_text(TERMINATOR);
    wait_drain();
    write_reg(u8lcd_pkg::CFG_COLUMN_LIMIT, 8'd0);
    send_text("x");
    send_text(TERMINATOR);
    wait_drain();
    set_config(8'd2, 8'h00, 8'd1);
    send_ascii("ab");
    send_text(8'hC4);
    send_text(TERMINATOR);
    wait_drain();
    // limit dropped under the columns already used
    write_reg(u8lcd_pkg::CFG_COLUMN_LIMIT, 8'd16);
    send_ascii("abcd");
    wait_drain();
    write_reg(u8lcd_pkg::CFG_COLUMN_LIMIT, 8'd2);
    send_text("e");
    send_text(TERMINATOR);
    wait_drain();
    set_config(8'd63, 8'hFF, 8'd1);
    send_text("z");
    send_text(TERMINATOR);
    wait_drain();
  endtask

  task automatic test_unknown_register();
    write_reg(CFG_UNUSED, 8'hFF);
    write_reg(u8lcd_pkg::CFG_PAD_ENABLE, 8'hFE);
    send_text(TERMINATOR);
    wait_drain();
    set_config(8'hC5, 8'h2E, 8'h01);
    send_text(TERMINATOR);
    wait_drain();
  endtask

  task automatic test_random_text();
    int unsigned target;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(8'd16, 8'h20, 8'd1);
        1: set_config(8'd1, 8'hFF, 8'd1);
        2: set_config(8'd40, 8'h00, 8'd0);
        3: set_config(8'd63, 8'h5F, 8'd1);
        4: set_config(8'd0, 8'hAA, 8'd1);
        default: set_config(8'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 1)));
      endcase
      tx_gaps = (p % 3) != 1;
      rx_gaps = (p % 3) != 2;
      target  = text_count + PHASE_ITEMS;
      while (text_count < target) send_random_string();
      wait_drain();
    end
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
  endtask

  task automatic test_output_stall();
    set_config(8'd40, 8'h2D, 8'd1);
    tx_gaps = 1'b0;
    @(negedge clk);
    hold_req = HOLD_CYCLES;
    send_ascii("Zazolc gesla jazn ");
    send_text(8'hC4); send_text(8'h85);
    send_text(8'hC5); send_text(8'h82);
    send_text(TERMINATOR);
    send_ascii("next");
    send_text(TERMINATOR);
    wait_drain();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.text_byte  = 8'h00;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = u8lcd_pkg::CFG_COLUMN_LIMIT;
    cfg_if.data      = 8'h00;
    out_if.ready     = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_plain_bytes();
    test_lead_bytes();
    test_column_limit();
    test_unknown_register();
    test_random_text();
    test_output_stall();
    if (expected_words.size() != 0)
      report_mismatch("words left over", 0, expected_words.size());
    if (errors == 0) begin
      $display("utf8_polish_to_lcd_column_writer_core_tb: PASS");
    end else begin
      $display("utf8_polish_to_lcd_column_writer_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("utf8_polish_to_lcd_column_writer_core_tb: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/u8lcd_pkg.sv
rtl/u8lcd_if.sv
rtl/u8lcd_front.sv
rtl/u8lcd_fifo.sv
rtl/u8lcd_back.sv
rtl/utf8_polish_to_lcd_column_writer_core.sv
bench/utf8_polish_to_lcd_column_writer_core_tb.sv
